[hw/rtl/s3x_pkg.sv]
// Shared constants, types and codes of the Scale3x alpha smoothing filter.
package s3x_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int PIX_W      = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int CFG_W_W    = 11;
    localparam int CFG_H_W    = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;
    // One bit above the height field so that the row count can saturate past any height.
    localparam int ROW_W      = CFG_H_W + 1;
    localparam int POS_W      = 22;
    localparam int OUT_Y_W    = POS_W - 1;
    localparam int WH_W       = CFG_W_W + CFG_H_W;
    localparam int DIV_CNT_W  = $clog2(POS_W);
    localparam int SUM_W      = PIX_W + 4;
    localparam int WIN_N      = 9;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_W_W-1:0] MIN_W       = CFG_W_W'(3);
    localparam logic [CFG_W_W-1:0] MAX_W       = CFG_W_W'(MAX_WIDTH);
    localparam logic [CFG_W_W-1:0] RESET_W     = CFG_W_W'(1024);
    localparam logic [CFG_H_W-1:0] MIN_H       = CFG_H_W'(3);
    localparam logic [CFG_H_W-1:0] RESET_H     = CFG_H_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT
    } t_reg_idx;

    typedef enum logic {
        ST_RUN,
        ST_DIV
    } t_ctl_state;

    typedef logic [WIN_N-1:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic             valid;
        logic             emit;
        logic             border;
        logic             frame_end;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
    } t_s1;

    typedef struct packed {
        logic valid;
        logic border;
        logic frame_end;
    } t_s2;

    typedef struct packed {
        logic [PIX_W-1:0] alpha;
        logic             frame_end;
    } t_res;

endpackage

[hw/rtl/s3x_if.sv]
// Stream and configuration channel interfaces of the Scale3x alpha smoothing filter.
interface s3x_pix_if;
    logic                      valid;
    logic                      ready;
    logic [s3x_pkg::PIX_W-1:0] pixel_alpha;
    logic                      flush;

    modport source (output valid, output pixel_alpha, output flush, input ready);
    modport sink   (input valid, input pixel_alpha, input flush, output ready);
endinterface

interface s3x_res_if;
    logic                      valid;
    logic                      ready;
    logic [s3x_pkg::PIX_W-1:0] alpha_out;
    logic                      frame_end;

    modport source (output valid, output alpha_out, output frame_end, input ready);
    modport sink   (input valid, input alpha_out, input frame_end, output ready);
endinterface

interface s3x_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [s3x_pkg::CFG_IDX_W-1:0]  addr;
    logic [s3x_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

[hw/rtl/scale3x_alpha_smoothing_filter.sv]
// Top level of the Scale3x alpha smoothing filter.
// Pixels enter in raster order at one beat per clock; each pixel reads and writes back one
// column of a single line memory that holds the two previous rows, then the 3x3 window
// shifts and the Scale3x weighted average is formed, so a result reaches the four-beat
// output queue after the s1 and s2 stages. Results lag the input by one row plus one pixel
// in beats; once the last pixel is in, any beats push out the pending results. Outside
// the divider pass, input stalls only when the output queue together with the results
// still in the pipeline would fill it. Every configuration write is followed by a pass
// of a bit-serial divider that maps the output position onto the new row width; no pixel
// is taken during that pass. The line memory needs no clearing after reset.
module scale3x_alpha_smoothing_filter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    s3x_pix_if.sink   i_pix,
    s3x_cfg_if.sink   i_cfg,
    s3x_res_if.source o_res
);

    s3x_pkg::t_rd_req               rd;
    s3x_pkg::t_s1                   s1;
    s3x_pkg::t_s2                   s2;
    s3x_pkg::t_win                  win;
    s3x_pkg::t_res                  res;
    logic [s3x_pkg::PIX_W-1:0]      alpha;
    logic [s3x_pkg::FIFO_LVL_W-1:0] fifo_lvl;

    s3x_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (i_pix),
        .i_cfg      (i_cfg),
        .i_fifo_lvl (fifo_lvl),
        .o_rd       (rd),
        .o_s1       (s1),
        .o_s2       (s2)
    );

    s3x_line_buf u_line_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd),
        .i_s1    (s1),
        .o_win   (win)
    );

    s3x_smooth u_smooth (
        .i_win    (win),
        .i_border (s2.border),
        .o_alpha  (alpha)
    );

    assign res.alpha     = alpha;
    assign res.frame_end = s2.frame_end;

    s3x_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s2.valid),
        .i_data  (res),
        .o_lvl   (fifo_lvl),
        .o_res   (o_res)
    );

endmodule

[hw/rtl/s3x_ctrl.sv]
// Control: configuration, raster position counters, position divider and pipeline control.
module s3x_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    s3x_pix_if.sink                        i_pix,
    s3x_cfg_if.sink                        i_cfg,
    input  logic [s3x_pkg::FIFO_LVL_W-1:0] i_fifo_lvl,
    output s3x_pkg::t_rd_req               o_rd,
    output s3x_pkg::t_s1                   o_s1,
    output s3x_pkg::t_s2                   o_s2
);

    s3x_pkg::t_ctl_state r_state, n_state;

    logic [s3x_pkg::CFG_W_W-1:0]   r_eff_w;
    logic [s3x_pkg::CFG_H_W-1:0]   r_eff_h;
    logic [s3x_pkg::WH_W-1:0]      r_wh;
    logic [s3x_pkg::COL_W-1:0]     r_in_col;
    logic [s3x_pkg::ROW_W-1:0]     r_in_row;
    logic [s3x_pkg::POS_W-1:0]     r_out_pos;
    logic [s3x_pkg::COL_W-1:0]     r_out_x;
    logic [s3x_pkg::OUT_Y_W-1:0]   r_out_y;
    logic [s3x_pkg::POS_W-1:0]     r_quo;
    logic [s3x_pkg::COL_W-1:0]     r_rem;
    logic [s3x_pkg::DIV_CNT_W-1:0] r_div_cnt;
    s3x_pkg::t_s1                  r_s1;
    s3x_pkg::t_s2                  r_s2;

    logic                          run;
    logic                          div_last;
    logic                          cfg_acc;
    logic                          accept;
    logic                          draining;
    logic                          ignore;
    logic                          take;
    logic                          emit;
    logic                          interior;
    logic                          frame_end;
    logic                          wrap;
    logic [s3x_pkg::COL_W-1:0]     col;
    logic [s3x_pkg::CFG_W_W-1:0]   col_inc;
    logic [s3x_pkg::CFG_W_W-1:0]   x_inc;
    logic [s3x_pkg::FIFO_LVL_W:0]  inflight;
    logic [s3x_pkg::CFG_W_W-1:0]   cfg_w_raw;
    logic [s3x_pkg::CFG_W_W-1:0]   cfg_w_eff;
    logic [s3x_pkg::CFG_H_W-1:0]   cfg_h_raw;
    logic [s3x_pkg::CFG_H_W-1:0]   cfg_h_eff;
    logic [s3x_pkg::COL_W:0]       rem_sh;
    logic                          rem_ge;
    logic [s3x_pkg::COL_W-1:0]     rem_nx;
    logic [s3x_pkg::POS_W-1:0]     quo_nx;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            s3x_pkg::ST_RUN: begin
                if (cfg_acc) begin
                    n_state = s3x_pkg::ST_DIV;
                end
            end
            s3x_pkg::ST_DIV: begin
                if (div_last) begin
                    n_state = s3x_pkg::ST_RUN;
                end
            end
            default: n_state = s3x_pkg::ST_RUN;
        endcase
    end

    // State outputs.
    always_comb begin
        run      = 1'b0;
        div_last = 1'b0;
        unique case (r_state)
            s3x_pkg::ST_RUN: run = 1'b1;
            s3x_pkg::ST_DIV: div_last = (r_div_cnt == s3x_pkg::DIV_CNT_W'(s3x_pkg::POS_W - 1));
            default: run = 1'b0;
        endcase
    end

    always_comb begin
        cfg_w_raw = i_cfg.data[s3x_pkg::CFG_W_W-1:0];
        cfg_h_raw = i_cfg.data[s3x_pkg::CFG_H_W-1:0];
        if (cfg_w_raw < s3x_pkg::MIN_W) begin
            cfg_w_eff = s3x_pkg::MIN_W;
        end else if (cfg_w_raw > s3x_pkg::MAX_W) begin
            cfg_w_eff = s3x_pkg::MAX_W;
        end else begin
            cfg_w_eff = cfg_w_raw;
        end
        cfg_h_eff = (cfg_h_raw < s3x_pkg::MIN_H) ? s3x_pkg::MIN_H : cfg_h_raw;
    end

    // The input stalls once the output queue and the results still in flight could fill it.
    assign inflight = (s3x_pkg::FIFO_LVL_W + 1)'(i_fifo_lvl)
                    + (s3x_pkg::FIFO_LVL_W + 1)'(r_s1.valid && r_s1.emit)
                    + (s3x_pkg::FIFO_LVL_W + 1)'(r_s2.valid);

    assign i_pix.ready = run && (inflight < (s3x_pkg::FIFO_LVL_W + 1)'(s3x_pkg::FIFO_DEPTH));
    assign i_cfg.ready = run;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign accept      = i_pix.valid && i_pix.ready;

    assign draining = (s3x_pkg::ROW_W'(r_eff_h) <= r_in_row);
    assign ignore   = i_pix.flush && !draining;
    assign take     = accept && !ignore;
    assign col      = (s3x_pkg::CFG_W_W'(r_in_col) >= r_eff_w) ? '0 : r_in_col;
    assign col_inc  = s3x_pkg::CFG_W_W'(col) + s3x_pkg::CFG_W_W'(1);
    assign wrap     = (col_inc >= r_eff_w);

    // Nothing comes out until the window has seen one row plus one pixel.
    assign emit = !((r_in_row == '0) ||
                    ((r_in_row == s3x_pkg::ROW_W'(1)) && (col == '0)));

    assign x_inc    = s3x_pkg::CFG_W_W'(r_out_x) + s3x_pkg::CFG_W_W'(1);
    assign interior = (r_out_y != '0) &&
                      ((s3x_pkg::POS_W'(r_out_y) + s3x_pkg::POS_W'(1)) <
                       s3x_pkg::POS_W'(r_eff_h)) &&
                      (r_out_x != '0) && (x_inc < r_eff_w);
    assign frame_end = ((s3x_pkg::WH_W'(r_out_pos) + s3x_pkg::WH_W'(1)) >= r_wh);

    // One restoring division step: output position by the row width.
    assign rem_sh = {r_rem, r_quo[s3x_pkg::POS_W-1]};
    assign rem_ge = (s3x_pkg::CFG_W_W'(rem_sh) >= r_eff_w);
    assign rem_nx = rem_ge ? s3x_pkg::COL_W'(s3x_pkg::CFG_W_W'(rem_sh) - r_eff_w)
                           : s3x_pkg::COL_W'(rem_sh);
    assign quo_nx = {r_quo[s3x_pkg::POS_W-2:0], rem_ge};

    assign o_rd.en   = take;
    assign o_rd.addr = col;
    assign o_s1      = r_s1;
    assign o_s2      = r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= s3x_pkg::ST_RUN;
            r_eff_w    <= s3x_pkg::RESET_W;
            r_eff_h    <= s3x_pkg::RESET_H;
            r_wh       <= s3x_pkg::WH_W'(s3x_pkg::RESET_W) * s3x_pkg::WH_W'(s3x_pkg::RESET_H);
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_pos  <= '0;
            r_out_x    <= '0;
            r_out_y    <= '0;
            r_div_cnt  <= '0;
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wh    <= s3x_pkg::WH_W'(r_eff_w) * s3x_pkg::WH_W'(r_eff_h);

            if (cfg_acc) begin
                unique case (s3x_pkg::t_reg_idx'(i_cfg.addr))
                    s3x_pkg::REG_IMAGE_WIDTH:  r_eff_w <= cfg_w_eff;
                    s3x_pkg::REG_IMAGE_HEIGHT: r_eff_h <= cfg_h_eff;
                    default: r_eff_w <= r_eff_w;
                endcase
                r_div_cnt <= '0;
            end else if (r_state == s3x_pkg::ST_DIV) begin
                r_div_cnt <= r_div_cnt + s3x_pkg::DIV_CNT_W'(1);
                if (div_last) begin
                    r_out_x <= rem_nx;
                    r_out_y <= quo_nx[s3x_pkg::OUT_Y_W-1:0];
                end
            end

            if (take) begin
                r_in_col <= wrap ? '0 : col_inc[s3x_pkg::COL_W-1:0];
                if (wrap && !r_in_row[s3x_pkg::ROW_W-1]) begin
                    r_in_row <= r_in_row + s3x_pkg::ROW_W'(1);
                end
                if (emit) begin
                    if (frame_end) begin
                        r_in_col  <= '0;
                        r_in_row  <= '0;
                        r_out_pos <= '0;
                        r_out_x   <= '0;
                        r_out_y   <= '0;
                    end else begin
                        r_out_pos <= r_out_pos + s3x_pkg::POS_W'(1);
                        if (x_inc >= r_eff_w) begin
                            r_out_x <= '0;
                            r_out_y <= r_out_y + s3x_pkg::OUT_Y_W'(1);
                        end else begin
                            r_out_x <= x_inc[s3x_pkg::COL_W-1:0];
                        end
                    end
                end
            end

            r_s1.valid     <= take;
            r_s2.valid     <= r_s1.valid && r_s1.emit;
        end

        // Payload of the pipeline and the divider datapath.
        if (cfg_acc) begin
            r_quo <= r_out_pos;
            r_rem <= '0;
        end else begin
            r_quo <= quo_nx;
            r_rem <= rem_nx;
        end
        r_s1.emit      <= emit;
        r_s1.border    <= !interior;
        r_s1.frame_end <= frame_end;
        r_s1.col       <= col;
        r_s1.pix       <= draining ? '0 : i_pix.pixel_alpha;
        r_s2.border    <= r_s1.border;
        r_s2.frame_end <= r_s1.frame_end;
    end

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        inflight <= (s3x_pkg::FIFO_LVL_W + 1)'(s3x_pkg::FIFO_DEPTH))
        else $error("output queue credit exceeded");

    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == s3x_pkg::ST_RUN) |-> (s3x_pkg::CFG_W_W'(r_out_x) < r_eff_w))
        else $error("output column outside the row");

    a_s2_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2.valid |-> $past(r_s1.valid && r_s1.emit))
        else $error("result stage valid without an emitting item");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && emit && frame_end) |=> ((r_out_pos == '0) && (r_in_row == '0)))
        else $error("counters not cleared after the last pixel");

endmodule

[hw/rtl/s3x_line_buf.sv]
// Two-row line memory with read, write back and the 3x3 window shift.
module s3x_line_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  s3x_pkg::t_rd_req i_rd,
    input  s3x_pkg::t_s1     i_s1,
    output s3x_pkg::t_win    o_win
);

    // Each entry holds the upper row pixel above the middle row pixel of one column.
    logic [2*s3x_pkg::PIX_W-1:0] r_mem [s3x_pkg::MAX_WIDTH];
    logic [2*s3x_pkg::PIX_W-1:0] r_rd_data;
    s3x_pkg::t_win               r_win;

    logic [s3x_pkg::PIX_W-1:0]   up;
    logic [s3x_pkg::PIX_W-1:0]   mid;

    assign up    = r_rd_data[2*s3x_pkg::PIX_W-1:s3x_pkg::PIX_W];
    assign mid   = r_rd_data[s3x_pkg::PIX_W-1:0];
    assign o_win = r_win;

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
        // The middle row moves up and the new pixel becomes the middle row.
        if (i_s1.valid) begin
            r_mem[i_s1.col] <= {mid, i_s1.pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_s1.valid) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= up;
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[5] <= mid;
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[8] <= i_s1.pix;
        end
    end

endmodule

[hw/rtl/s3x_smooth.sv]
// Scale3x sub-pixel selection and 1-2-1 weighted average of one window.
module s3x_smooth (
    input  s3x_pkg::t_win             i_win,
    input  logic                      i_border,
    output logic [s3x_pkg::PIX_W-1:0] o_alpha
);

    logic [s3x_pkg::PIX_W-1:0] a, b, c, d, e, f, g, h, k;
    logic [s3x_pkg::PIX_W-1:0] s0, s1, s2, s3, s5, s6, s7, s8;
    logic [s3x_pkg::SUM_W-1:0] sum;

    assign a = i_win[0];
    assign b = i_win[1];
    assign c = i_win[2];
    assign d = i_win[3];
    assign e = i_win[4];
    assign f = i_win[5];
    assign g = i_win[6];
    assign h = i_win[7];
    assign k = i_win[8];

    always_comb begin
        s0 = e;
        s1 = e;
        s2 = e;
        s3 = e;
        s5 = e;
        s6 = e;
        s7 = e;
        s8 = e;
        if ((b != h) && (d != f)) begin
            if (d == b) s0 = d;
            if (((d == b) && (e != c)) || ((b == f) && (e != a))) s1 = b;
            if (b == f) s2 = f;
            if (((d == b) && (e != g)) || ((d == h) && (e != a))) s3 = d;
            if (((b == f) && (e != k)) || ((h == f) && (e != c))) s5 = f;
            if (d == h) s6 = d;
            if (((d == h) && (e != k)) || ((h == f) && (e != g))) s7 = h;
            if (h == f) s8 = f;
        end
    end

    assign sum = s3x_pkg::SUM_W'(s0) + s3x_pkg::SUM_W'(s2)
               + s3x_pkg::SUM_W'(s6) + s3x_pkg::SUM_W'(s8)
               + (s3x_pkg::SUM_W'(s1) << 1) + (s3x_pkg::SUM_W'(s3) << 1)
               + (s3x_pkg::SUM_W'(s5) << 1) + (s3x_pkg::SUM_W'(s7) << 1)
               + (s3x_pkg::SUM_W'(e) << 2);

    assign o_alpha = i_border ? e : sum[s3x_pkg::SUM_W-1:4];

endmodule

[hw/rtl/s3x_out_fifo.sv]
// Small output queue that decouples the result stream from the pipeline.
module s3x_out_fifo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  s3x_pkg::t_res                  i_data,
    output logic [s3x_pkg::FIFO_LVL_W-1:0] o_lvl,
    s3x_res_if.source                      o_res
);

    s3x_pkg::t_res                 r_mem [s3x_pkg::FIFO_DEPTH];
    logic [s3x_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [s3x_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [s3x_pkg::FIFO_LVL_W-1:0] r_lvl;
    logic                           pop;
    s3x_pkg::t_res                  head;

    assign head            = r_mem[r_rd_ptr];
    assign o_res.valid     = (r_lvl != '0);
    assign o_res.alpha_out = head.alpha;
    assign o_res.frame_end = head.frame_end;
    assign pop             = o_res.valid && o_res.ready;
    assign o_lvl           = r_lvl;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_lvl    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == s3x_pkg::FIFO_PTR_W'(s3x_pkg::FIFO_DEPTH - 1)) ?
                            '0 : r_wr_ptr + s3x_pkg::FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == s3x_pkg::FIFO_PTR_W'(s3x_pkg::FIFO_DEPTH - 1)) ?
                            '0 : r_rd_ptr + s3x_pkg::FIFO_PTR_W'(1);
            end
            r_lvl <= r_lvl + s3x_pkg::FIFO_LVL_W'(i_push) - s3x_pkg::FIFO_LVL_W'(pop);
        end
    end

endmodule

[dv/s3x_smoothing_check.sv]
`timescale 1ns / 1ps
// Scoreboard that predicts and checks every result of the Scale3x alpha smoothing filter.
module s3x_smoothing_check (
    input  logic i_clk,
    input  logic i_rst_n,
    s3x_pix_if   i_pix,
    s3x_cfg_if   i_cfg,
    s3x_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_result_count,
    output int   o_frame_count,
    output logic o_frame_busy,
    output logic o_need_pixel
);

    logic [s3x_pkg::CFG_W_W-1:0] width_reg;
    logic [s3x_pkg::CFG_H_W-1:0] height_reg;
    logic [s3x_pkg::PIX_W-1:0]   line_above  [s3x_pkg::MAX_WIDTH];
    logic [s3x_pkg::PIX_W-1:0]   line_middle [s3x_pkg::MAX_WIDTH];
    s3x_pkg::t_win               nbhd;
    int unsigned                 next_col;
    int unsigned                 next_row;
    int unsigned                 next_out;
    s3x_pkg::t_res               expected_alpha [$];
    int                          mismatches;
    int                          results;
    int                          frames;

    function automatic int unsigned row_width();
        int unsigned w;
        w = width_reg;
        if (w < 3) w = 3;
        if (w > s3x_pkg::MAX_WIDTH) w = s3x_pkg::MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned frame_rows();
        int unsigned h;
        h = height_reg;
        return (h < 3) ? 3 : h;
    endfunction

    // Window layout: a b c / d e f / g h i with e at the center.
    function automatic logic [s3x_pkg::PIX_W-1:0] scale3x_mean(input s3x_pkg::t_win p);
        logic [s3x_pkg::PIX_W-1:0] a, b, c, d, e, f, g, h, i;
        int unsigned s0, s1, s2, s3, s5, s6, s7, s8;
        a = p[0]; b = p[1]; c = p[2];
        d = p[3]; e = p[4]; f = p[5];
        g = p[6]; h = p[7]; i = p[8];
        s0 = e; s1 = e; s2 = e; s3 = e; s5 = e; s6 = e; s7 = e; s8 = e;
        if (b != h && d != f) begin
            if (d == b) s0 = d;
            if ((d == b && e != c) || (b == f && e != a)) s1 = b;
            if (b == f) s2 = f;
            if ((d == b && e != g) || (d == h && e != a)) s3 = d;
            if ((b == f && e != i) || (h == f && e != c)) s5 = f;
            if (d == h) s6 = d;
            if ((d == h && e != i) || (h == f && e != g)) s7 = h;
            if (h == f) s8 = f;
        end
        return s3x_pkg::PIX_W'((s0 + 2 * s1 + s2 + 2 * s3 + 4 * e + 2 * s5 + s6 + 2 * s7 + s8)
                               / 16);
    endfunction

    task automatic clear_predictor();
        int k;
        width_reg  = s3x_pkg::RESET_W;
        height_reg = s3x_pkg::RESET_H;
        for (k = 0; k < s3x_pkg::MAX_WIDTH; k++) begin
            line_above[k]  = '0;
            line_middle[k] = '0;
        end
        nbhd     = '0;
        next_col = 0;
        next_row = 0;
        next_out = 0;
        expected_alpha.delete();
    endtask

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("MISMATCH @ %0t ns: %s", $time, what);
    endtask

    task automatic take_pixel(input logic [s3x_pkg::PIX_W-1:0] alpha, input logic flush);
        int unsigned w, h, col, n, x, y;
        logic        draining;
        logic [s3x_pkg::PIX_W-1:0] px, up, mid;
        s3x_pkg::t_res want;
        w = row_width();
        h = frame_rows();
        draining = next_row >= h;
        // A flush while the frame still wants pixels does nothing.
        if (flush && !draining) return;
        px = draining ? '0 : alpha;
        if (next_col >= w) next_col = 0;
        col = next_col;
        n = next_row * w + col;

        up  = line_above[col];
        mid = line_middle[col];
        line_above[col]  = mid;
        line_middle[col] = px;
        nbhd[0] = nbhd[1]; nbhd[1] = nbhd[2]; nbhd[2] = up;
        nbhd[3] = nbhd[4]; nbhd[4] = nbhd[5]; nbhd[5] = mid;
        nbhd[6] = nbhd[7]; nbhd[7] = nbhd[8]; nbhd[8] = px;

        next_col = col + 1;
        if (next_col >= w) begin
            next_col = 0;
            next_row++;
        end
        if (n < w + 1) return;

        y = next_out / w;
        x = next_out % w;
        if (y >= 1 && y + 1 < h && x >= 1 && x + 1 < w) want.alpha = scale3x_mean(nbhd);
        else want.alpha = nbhd[4];
        want.frame_end = (next_out + 1 >= w * h);
        expected_alpha.push_back(want);
        if (want.frame_end) begin
            next_col = 0;
            next_row = 0;
            next_out = 0;
            frames++;
        end else begin
            next_out++;
        end
    endtask

    task automatic check_result(input logic [s3x_pkg::PIX_W-1:0] alpha, input logic last);
        s3x_pkg::t_res want;
        results++;
        if (expected_alpha.size() == 0) begin
            flag_mismatch($sformatf("result %0d (alpha %0d, frame_end %0b) with none pending",
                                    results, alpha, last));
            return;
        end
        want = expected_alpha.pop_front();
        if (alpha !== want.alpha)
            flag_mismatch($sformatf("result %0d: alpha_out %0d, predicted %0d",
                                    results, alpha, want.alpha));
        if (last !== want.frame_end)
            flag_mismatch($sformatf("result %0d: frame_end %0b, predicted %0b",
                                    results, last, want.frame_end));
    endtask

    initial begin
        mismatches = 0;
        results    = 0;
        frames     = 0;
    end

    // Inputs change on the falling edge, so everything seen here is settled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_predictor();
        end else begin
            if (i_res.valid && i_res.ready) check_result(i_res.alpha_out, i_res.frame_end);
            if (i_cfg.valid && i_cfg.ready) begin
                case (s3x_pkg::t_reg_idx'(i_cfg.addr))
                    s3x_pkg::REG_IMAGE_WIDTH:  width_reg  = i_cfg.data[s3x_pkg::CFG_W_W-1:0];
                    s3x_pkg::REG_IMAGE_HEIGHT: height_reg = i_cfg.data[s3x_pkg::CFG_H_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready) take_pixel(i_pix.pixel_alpha, i_pix.flush);
        end
        o_fail_count   = mismatches;
        o_pending      = expected_alpha.size();
        o_result_count = results;
        o_frame_count  = frames;
        o_frame_busy   = (next_col != 0) || (next_row != 0) || (next_out != 0);
        o_need_pixel   = next_row < frame_rows();
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Top of the smoothing filter testbench: clock, reset, stimulus and the final verdict.
module testbench;

    // The limit leaves a wide margin over the slowest correct run.
    localparam int unsigned CYCLE_LIMIT   = 400_000;
    localparam int unsigned RANDOM_PIXELS = 520;
    localparam int unsigned CLAMP_PIXELS  = 24;
    localparam int unsigned CALM_PIXELS   = 200;
    localparam int unsigned TAIL_CYCLES   = 32;

    typedef enum int {
        TONES_FULL,
        TONES_TWO,
        TONES_THREE
    } t_tones;

    logic i_clk = 1'b0;
    logic i_rst_n;

    s3x_pix_if pix ();
    s3x_cfg_if cfg ();
    s3x_res_if res ();

    int   fail_count;
    int   pending_results;
    int   result_count;
    int   frame_count;
    logic frame_busy;
    logic need_pixel;

    int unsigned               cycle_count = 0;
    int unsigned               src_idle_pct;
    int unsigned               snk_idle_pct;
    int unsigned               pixel_beats = 0;
    int unsigned               reg_writes  = 0;
    t_tones                    tones;
    logic [s3x_pkg::PIX_W-1:0] palette [3];

    scale3x_alpha_smoothing_filter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    s3x_smoothing_check scoreboard (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pix          (pix),
        .i_cfg          (cfg),
        .i_res          (res),
        .o_fail_count   (fail_count),
        .o_pending      (pending_results),
        .o_result_count (result_count),
        .o_frame_count  (frame_count),
        .o_frame_busy   (frame_busy),
        .o_need_pixel   (need_pixel)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results pending.",
                     cycle_count, pending_results);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        res.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    function automatic logic [s3x_pkg::PIX_W-1:0] next_alpha();
        case (tones)
            TONES_FULL: return s3x_pkg::PIX_W'($urandom_range(255));
            TONES_TWO:  return palette[$urandom_range(1)];
            default:    return palette[$urandom_range(2)];
        endcase
    endfunction

    // Few distinct tones make the edge rule fire often; full range covers every bit.
    task automatic new_palette();
        tones = t_tones'($urandom_range(2));
        palette[0] = s3x_pkg::PIX_W'($urandom_range(255));
        palette[1] = s3x_pkg::PIX_W'($urandom_range(255));
        palette[2] = s3x_pkg::PIX_W'($urandom_range(255));
        if (tones == TONES_THREE) begin
            palette[0] = '0;
            palette[1] = '1;
        end
    endtask

    // Called on a falling edge; returns on the falling edge after the beat is taken,
    // with valid still high.
    task automatic send_item(input logic [s3x_pkg::PIX_W-1:0] alpha, input logic flush);
        while ($urandom_range(99) < src_idle_pct) begin
            pix.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix.valid       <= 1'b1;
        pix.pixel_alpha <= alpha;
        pix.flush       <= flush;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic settle();
        pix.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results != 0) @(negedge i_clk);
        // Ignored beats leave no result behind, so give the pipeline time to empty.
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input s3x_pkg::t_reg_idx idx,
                             input logic [s3x_pkg::CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.addr  <= idx;
        cfg.data  <= value;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg.valid <= 1'b0;
        @(negedge i_clk);
        reg_writes++;
    endtask

    task automatic resize_mid_frame(input logic shrink);
        if (shrink || $urandom_range(1) == 0)
            write_reg(s3x_pkg::REG_IMAGE_WIDTH,
                      s3x_pkg::CFG_DATA_W'($urandom_range(3, 12)));
        if (shrink || $urandom_range(1) == 0)
            write_reg(s3x_pkg::REG_IMAGE_HEIGHT,
                      s3x_pkg::CFG_DATA_W'($urandom_range(3, shrink ? 6 : 8)));
    endtask

    // Streams one frame and drains it. After pixel_cap pixels the frame is cut short by a
    // mid-frame resize; change_odds gives random mid-frame resizes (zero turns them off).
    task automatic stream_frame(input int unsigned pixel_cap, input int unsigned change_odds);
        int unsigned sent;
        send_item(next_alpha(), 1'b0);
        sent = 1;
        pixel_beats++;
        while (frame_busy) begin
            if (!need_pixel) begin
                // Draining: mostly flushes, now and then a pixel that gets dropped.
                send_item(next_alpha(), $urandom_range(3) != 0);
            end else if (sent >= pixel_cap) begin
                settle();
                resize_mid_frame(1'b1);
                pixel_cap = 32'hFFFF_FFFF;
            end else if (change_odds != 0 && $urandom_range(change_odds - 1) == 0) begin
                settle();
                resize_mid_frame(1'b0);
            end else if ($urandom_range(15) == 0) begin
                send_item(next_alpha(), 1'b1);
            end else begin
                if ($urandom_range(199) == 0) settle();
                send_item(next_alpha(), 1'b0);
                sent++;
                pixel_beats++;
            end
        end
        settle();
    endtask

    initial begin
        logic [s3x_pkg::PIX_W-1:0] edge_img [9];
        logic [s3x_pkg::PIX_W-1:0] flat_img [9];
        int unsigned               w, h, pick, frame_no, random_start;

        // Center sits between two distinct tones: corners pull toward the matching sides.
        edge_img = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd128, 8'd255, 8'd255, 8'd255, 8'd0};
        // Top and bottom neighbors agree, so the center passes through.
        flat_img = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0};

        pix.valid       = 1'b0;
        pix.pixel_alpha = '0;
        pix.flush       = 1'b0;
        cfg.valid       = 1'b0;
        cfg.addr        = s3x_pkg::REG_IMAGE_WIDTH;
        cfg.data        = '0;
        src_idle_pct    = 32;
        snk_idle_pct    = 32;
        tones           = TONES_FULL;
        i_rst_n         = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Smallest image, with a flush in mid-frame and a pixel sent during the drain.
        write_reg(s3x_pkg::REG_IMAGE_WIDTH, s3x_pkg::CFG_DATA_W'(3));
        write_reg(s3x_pkg::REG_IMAGE_HEIGHT, s3x_pkg::CFG_DATA_W'(3));
        for (int k = 0; k < 9; k++) begin
            if (k == 5) send_item(8'hFF, 1'b1);
            send_item(edge_img[k], 1'b0);
        end
        send_item(8'hFF, 1'b0);
        repeat (3) send_item(8'h00, 1'b1);
        for (int k = 0; k < 9; k++) send_item(flat_img[k], 1'b0);
        repeat (4) send_item(8'h00, 1'b1);
        pixel_beats += 18;
        settle();

        // Every register bit set: width clamps to the maximum, height is the largest.
        // A few pixels in, the frame is resized on the fly and then drained.
        write_reg(s3x_pkg::REG_IMAGE_WIDTH, '1);
        write_reg(s3x_pkg::REG_IMAGE_HEIGHT, '1);
        new_palette();
        stream_frame(CLAMP_PIXELS, 0);

        frame_no     = 0;
        random_start = pixel_beats;
        while (pixel_beats - random_start < RANDOM_PIXELS) begin
            // The first stretch of random frames runs with both sides at full rate.
            pick = (pixel_beats - random_start < CALM_PIXELS) ? 0 : 32;
            src_idle_pct = pick;
            snk_idle_pct = pick;

            pick = $urandom_range(99);
            if (pick < 8) w = $urandom_range(2);
            else if (pick < 80) w = $urandom_range(3, 10);
            else w = $urandom_range(11, 48);
            pick = $urandom_range(99);
            if (pick < 8) h = $urandom_range(2);
            else if (pick < 14) h = 4095;
            else h = $urandom_range(3, 8);

            write_reg(s3x_pkg::REG_IMAGE_WIDTH,
                      {1'($urandom_range(1)), s3x_pkg::CFG_W_W'(w)});
            write_reg(s3x_pkg::REG_IMAGE_HEIGHT, s3x_pkg::CFG_DATA_W'(h));
            new_palette();
            stream_frame(400, ($urandom_range(4) == 0) ? 40 : 0);
            frame_no++;
        end

        pix.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Sent %0d pixel beats in %0d frames; %0d results checked after %0d writes.",
                 pixel_beats, frame_count, result_count, reg_writes);
        $display("Widths ran from the 3-pixel floor to the 1024 clamp, heights to 4095 rows.");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches.", fail_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
